// ----- rtl/lpos_pkg.sv -----
// Shared types and constants of the lowest-precedence operator scan.
// Used by the channel interfaces and by the top level; depends on nothing.
package lpos_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 4096;
   localparam int unsigned POS_OUT_W = 12;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NO_OP     = 2'd1,
      ST_UNMATCHED = 2'd2,
      ST_TOO_LONG  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_MUL   = 4'd3,
      OP_DIV   = 4'd4,
      OP_POW   = 4'd5,
      OP_EQ    = 4'd6,
      OP_GE    = 4'd7,
      OP_LE    = 4'd8,
      OP_NE    = 4'd9,
      OP_GT    = 4'd10,
      OP_LT    = 4'd11,
      OP_AND   = 4'd12,
      OP_OR    = 4'd13
   } op_code_type;

   localparam logic [2:0] PREC_LOGIC = 3'd1;
   localparam logic [2:0] PREC_CMP   = 3'd2;
   localparam logic [2:0] PREC_ADD   = 3'd3;
   localparam logic [2:0] PREC_MUL   = 3'd4;
   localparam logic [2:0] PREC_POW   = 3'd5;
   localparam logic [2:0] PREC_NONE  = 3'd6;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef struct packed {
      status_type           status;
      logic [POS_OUT_W-1:0] op_position;
      op_code_type          op_code;
   } result_type;

endpackage

// ----- rtl/lpos_if.sv -----
// Valid/ready channel interfaces of the lowest-precedence operator scan.
// The request channel carries characters, the response channel results; uses lpos_pkg.
interface lpos_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface lpos_rsp_if;
   logic                           valid;
   logic                           ready;
   lpos_pkg::status_type           status;
   logic [lpos_pkg::POS_OUT_W-1:0] op_position;
   lpos_pkg::op_code_type          op_code;

   modport source (output valid, output status, output op_position, output op_code,
                   input ready);
   modport sink (input valid, input status, input op_position, input op_code,
                 output ready);
endinterface

// ----- rtl/lowest_precedence_operator_scan.sv -----
// Top level of the lowest-precedence operator scan: per-character state update and
// a two-entry registered response buffer. Depends on lpos_pkg and lpos_if.
//
// The block takes one character request per clock cycle and, on the request that
// carries the final character, produces one registered response naming the
// top-level operator of lowest precedence (rightmost on a tie), with bracketed text
// skipped. A '>', '<' or '!' is held back for one character to recognise '>=', '<='
// and '!='. The rate is one character per cycle, set by the single state-update path
// that runs between the scan registers; the response is registered, and a second
// response register lets characters keep flowing while a result waits to be taken.
// Requests stall only when both response registers are full. Expressions longer
// than MAX_LEN characters report too long.
module lowest_precedence_operator_scan #(
   parameter int unsigned MAX_LEN = lpos_pkg::MAX_LEN_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   lpos_req_if.sink     req_chan,
   lpos_rsp_if.source   rsp_chan
);
   import lpos_pkg::*;

   localparam int unsigned IdxW = $clog2(MAX_LEN + 1);
   localparam int unsigned PosW = $clog2(MAX_LEN);

   typedef enum logic [1:0] {
      SKIP_NONE,
      SKIP_ROUND,
      SKIP_SQUARE
   } skip_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_GT,
      PEND_LT,
      PEND_NOT
   } pend_type;

   typedef struct packed {
      logic [2:0]      prec;
      logic [PosW-1:0] pos;
      op_code_type     op;
   } best_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  prec;
      op_code_type op;
   } decode_type;

   function automatic best_type offer(best_type cur, logic [2:0] prec, op_code_type op,
                                      logic [PosW-1:0] pos);
      best_type r;
      r = cur;
      if (cur.prec >= prec) begin
         r.prec = prec;
         r.pos  = pos;
         r.op   = op;
      end
      return r;
   endfunction

   function automatic best_type settle(best_type cur, pend_type pend, logic [PosW-1:0] pos);
      best_type r;
      r = cur;
      unique case (pend)
         PEND_GT: r = offer(cur, PREC_CMP, OP_GT, pos);
         PEND_LT: r = offer(cur, PREC_CMP, OP_LT, pos);
         default: r = cur;
      endcase
      return r;
   endfunction

   function automatic decode_type decode(logic [7:0] c);
      decode_type d;
      d = '{hit: 1'b1, prec: PREC_NONE, op: OP_NONE};
      unique case (c)
         CH_PLUS:  begin d.prec = PREC_ADD;   d.op = OP_ADD; end
         CH_MINUS: begin d.prec = PREC_ADD;   d.op = OP_SUB; end
         CH_STAR:  begin d.prec = PREC_MUL;   d.op = OP_MUL; end
         CH_SLASH: begin d.prec = PREC_MUL;   d.op = OP_DIV; end
         CH_CARET: begin d.prec = PREC_POW;   d.op = OP_POW; end
         CH_EQUAL: begin d.prec = PREC_CMP;   d.op = OP_EQ;  end
         CH_AMP:   begin d.prec = PREC_LOGIC; d.op = OP_AND; end
         CH_BAR:   begin d.prec = PREC_LOGIC; d.op = OP_OR;  end
         default:  d.hit = 1'b0;
      endcase
      return d;
   endfunction

   localparam best_type BEST_RESET = '{prec: PREC_NONE, pos: '0, op: OP_NONE};

   logic [IdxW-1:0] idx_ff, idx_in;
   logic            too_long_ff, too_long_in;
   skip_type        skip_ff, skip_in;
   logic [IdxW-1:0] depth_ff, depth_in;
   best_type        best_ff, best_in;
   pend_type        pend_ff, pend_in;
   logic [PosW-1:0] pend_pos_ff, pend_pos_in;

   logic            out_valid_ff, out_valid_in;
   result_type      out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   result_type      skid_ff, skid_in;

   logic            req_fire;
   logic            rsp_fire;
   logic            res_fire;
   result_type      res;
   logic [PosW-1:0] here;
   logic [7:0]      opener;
   logic [7:0]      closer;
   decode_type      dec;
   best_type        final_best;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign res_fire = req_fire && req_chan.last_char;
   assign here     = idx_ff[PosW-1:0];
   assign opener   = (skip_ff == SKIP_ROUND) ? CH_LPAREN : CH_LBRACK;
   assign closer   = (skip_ff == SKIP_ROUND) ? CH_RPAREN : CH_RBRACK;
   assign dec      = decode(req_chan.char_code);

   always_comb begin
      idx_in      = idx_ff;
      too_long_in = too_long_ff;
      skip_in     = skip_ff;
      depth_in    = depth_ff;
      best_in     = best_ff;
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;
      final_best  = best_ff;
      res         = '{status: ST_NO_OP, op_position: '0, op_code: OP_NONE};
      if (req_fire) begin
         if (idx_ff >= IdxW'(MAX_LEN)) begin
            too_long_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            if (skip_ff != SKIP_NONE) begin
               if (req_chan.char_code == opener) begin
                  depth_in = depth_ff + 1'b1;
               end else if (req_chan.char_code == closer) begin
                  depth_in = depth_ff - 1'b1;
                  if (depth_in == '0) begin
                     skip_in = SKIP_NONE;
                  end
               end
            end else if (pend_ff != PEND_NONE && req_chan.char_code == CH_EQUAL) begin
               unique case (pend_ff)
                  PEND_GT: best_in = offer(best_ff, PREC_CMP, OP_GE, pend_pos_ff);
                  PEND_LT: best_in = offer(best_ff, PREC_CMP, OP_LE, pend_pos_ff);
                  default: best_in = offer(best_ff, PREC_CMP, OP_NE, pend_pos_ff);
               endcase
               pend_in = PEND_NONE;
            end else begin
               best_in = settle(best_ff, pend_ff, pend_pos_ff);
               pend_in = PEND_NONE;
               if (dec.hit) begin
                  best_in = offer(best_in, dec.prec, dec.op, here);
               end
               unique case (req_chan.char_code)
                  CH_LPAREN: begin skip_in = SKIP_ROUND;  depth_in = IdxW'(1); end
                  CH_LBRACK: begin skip_in = SKIP_SQUARE; depth_in = IdxW'(1); end
                  CH_GT:     begin pend_in = PEND_GT;  pend_pos_in = here; end
                  CH_LT:     begin pend_in = PEND_LT;  pend_pos_in = here; end
                  CH_BANG:   begin pend_in = PEND_NOT; pend_pos_in = here; end
                  default:   ;
               endcase
            end
         end
         if (req_chan.last_char) begin
            final_best = settle(best_in, pend_in, pend_pos_in);
            if (too_long_in) begin
               res.status = ST_TOO_LONG;
            end else if (skip_in != SKIP_NONE) begin
               res.status = ST_UNMATCHED;
            end else if (final_best.op == OP_NONE) begin
               res.status = ST_NO_OP;
            end else begin
               res.status      = ST_FOUND;
               res.op_position = POS_OUT_W'(final_best.pos);
               res.op_code     = final_best.op;
            end
            idx_in      = '0;
            too_long_in = 1'b0;
            skip_in     = SKIP_NONE;
            depth_in    = '0;
            best_in     = BEST_RESET;
            pend_in     = PEND_NONE;
            pend_pos_in = '0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_fire;
            out_in       = res;
         end
      end else if (res_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         too_long_ff   <= 1'b0;
         skip_ff       <= SKIP_NONE;
         depth_ff      <= '0;
         best_ff       <= BEST_RESET;
         pend_ff       <= PEND_NONE;
         pend_pos_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         too_long_ff   <= too_long_in;
         skip_ff       <= skip_in;
         depth_ff      <= depth_in;
         best_ff       <= best_in;
         pend_ff       <= pend_in;
         pend_pos_ff   <= pend_pos_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_chan.ready       = !skid_valid_ff;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.op_position = out_ff.op_position;
   assign rsp_chan.op_code     = out_ff.op_code;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Second response register holds a result while the first is empty.");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      res_fire |=> (idx_ff == '0 && skip_ff == SKIP_NONE && pend_ff == PEND_NONE
                    && best_ff.prec == PREC_NONE && !too_long_ff))
      else $error("Scan state not cleared after the final character.");

   a_skip_depth: assert property (@(posedge clock) disable iff (reset)
      skip_ff != SKIP_NONE |-> depth_ff != '0)
      else $error("Bracket skip active with zero nesting depth.");

   a_found_has_op: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == ST_FOUND) |-> out_ff.op_code != OP_NONE)
      else $error("Response reports an operator found without an operator code.");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IdxW'(MAX_LEN))
      else $error("Character index beyond the maximum length.");
`endif

endmodule
